@@ rtl/argb_to_mono_page_packer_macros.svh @@
// Assertion macros for the ARGB to mono page packer.
`ifndef ARGB_TO_MONO_PAGE_PACKER_MACROS_SVH
`define ARGB_TO_MONO_PAGE_PACKER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is high.
`define A2M_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked check that also holds across reset.
`define A2M_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define A2M_ASSERT(lbl, prop, msg)
`define A2M_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/a2m_pkg.sv @@
// Shared constants, register codes and helpers for the ARGB to mono page packer.
`timescale 1ns / 1ps

package a2m_pkg;

   localparam int MaxWidthDef  = 256;
   localparam int MaxHeightDef = 256;

   localparam logic [8:0] WidthReset  = 9'd128;
   localparam logic [8:0] HeightReset = 9'd64;

   typedef enum logic [1:0] {
      REG_KEY_COLOR,
      REG_BACKGROUND_COLOR,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } a2m_reg_type;

   // Floor of x / 255 for any x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

endpackage

@@ rtl/a2m_blend.sv @@
// Two-stage alpha blend of one ARGB pixel onto the background colour.
`timescale 1ns / 1ps

module a2m_blend
   import a2m_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [7:0]  alpha,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   input  logic [23:0] background,
   output logic [23:0] rgb
);

   logic [7:0]  inv_alpha;
   logic [15:0] prod_c_ff [3];
   logic [15:0] prod_b_ff [3];
   logic [23:0] rgb_ff;
   logic [7:0]  chan [3];
   logic [7:0]  bgch [3];

   // An opaque pixel comes out unchanged: c*255/255 is exact.
   assign inv_alpha = 8'd255 - alpha;
   assign chan[0]   = red;
   assign chan[1]   = green;
   assign chan[2]   = blue;
   assign bgch[0]   = background[23:16];
   assign bgch[1]   = background[15:8];
   assign bgch[2]   = background[7:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            prod_c_ff[i] <= chan[i] * alpha;
            prod_b_ff[i] <= bgch[i] * inv_alpha;
         end
         rgb_ff <= {div255(prod_c_ff[0] + prod_b_ff[0]),
                    div255(prod_c_ff[1] + prod_b_ff[1]),
                    div255(prod_c_ff[2] + prod_b_ff[2])};
      end
   end

   assign rgb = rgb_ff;

endmodule

@@ rtl/argb_to_mono_page_packer.sv @@
// Top level of the ARGB to mono page packer: counters, page buffer and output register.
`timescale 1ns / 1ps
`include "argb_to_mono_page_packer_macros.svh"

// ARGB pixels arrive in raster order on the req_ stream, one beat per pixel.
// Each pixel is blended onto the background colour when its alpha is below
// 255, compared with the key colour, and its bit is merged into a one-byte
// entry per column of a page buffer (bit = row mod 8; the first row of a
// page overwrites the entry). On the last row of a page, or of the image,
// every pixel sends its column's finished byte as one rsp_ beat; tlast marks
// the final byte of the image.
// Throughput: one pixel per cycle unless rsp_ stalls. The page buffer is a single
// memory read one stage ahead of its write; a pixel that hits the column
// written in the same cycle takes the forwarded byte.
// Each accepted pixel passes through the products, then the divide and buffer
// read, then the merge into the output register that drives rsp_tvalid.
// When rsp_tready is low with a result waiting, the whole pipeline holds
// and req_tready drops in the same cycle.
// Reset clears the counters, the pipeline control state and the registers (width 128,
// height 64, colours 0). The page buffer needs no clearing: each page
// starts by overwriting its entries. The user must write registers on the
// csr_ port only while the block is idle; the block does not enforce this.
module argb_to_mono_page_packer
   import a2m_pkg::*;
#(
   parameter int MAX_WIDTH  = MaxWidthDef,
   parameter int MAX_HEIGHT = MaxHeightDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // alpha[7:0], red[15:8], green[23:16], blue[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // page_byte[7:0], column[15:8], page[20:16], zero pad
   output logic        rsp_tlast,   // last_byte
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int ColBits   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RowBits   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WSizeBits = (ColBits + 1 > 10) ? ColBits + 1 : 10;
   localparam int HSizeBits = (RowBits + 1 > 10) ? RowBits + 1 : 10;

   typedef struct packed {
      logic               valid;
      logic [ColBits-1:0] col;
      logic [2:0]         bit_idx;
      logic               first;
      logic               emit;
      logic               last;
      logic [4:0]         page;
      logic [7:0]         column;
   } ctl_type;

   // configuration
   logic [23:0] key_ff, bg_ff;
   logic [8:0]  width_ff, height_ff;

   // counters
   logic [ColBits-1:0]   col_ff, col_in;
   logic [RowBits-1:0]   row_ff, row_in;
   logic [WSizeBits-1:0] w_eff, col_p1;
   logic [HSizeBits-1:0] h_eff, row_p1;
   logic                 row_end, last_row;
   logic [ColBits+7:0]   col_x;
   logic [RowBits+7:0]   row_x;

   // pipeline
   logic    adv, req_accept;
   ctl_type ctl_new, s1_ff, s2_ff;
   logic [23:0] rgb;
   logic [7:0]  buf_mem [MAX_WIDTH];
   logic [7:0]  rd_ff;
   logic        fwd_hit_ff;
   logic [7:0]  fwd_data_ff;
   logic [7:0]  old_byte, bit_mask, new_byte;
   logic        pix_on;

   // output register
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff, out_column_ff;
   logic [4:0]  out_page_ff;
   logic        out_last_ff;

   assign csr_ready  = 1'b1;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         bg_ff     <= '0;
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_valid) begin
         case (a2m_reg_type'(csr_index))
            REG_KEY_COLOR:        key_ff    <= csr_data;
            REG_BACKGROUND_COLOR: bg_ff     <= csr_data;
            REG_IMAGE_WIDTH:      width_ff  <= csr_data[8:0];
            REG_IMAGE_HEIGHT:     height_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes: zero acts as one, above the maximum acts as the maximum.
   always_comb begin
      w_eff = WSizeBits'(width_ff);
      if (width_ff == '0) begin
         w_eff = WSizeBits'(1);
      end else if (w_eff > WSizeBits'(MAX_WIDTH)) begin
         w_eff = WSizeBits'(MAX_WIDTH);
      end
      h_eff = HSizeBits'(height_ff);
      if (height_ff == '0) begin
         h_eff = HSizeBits'(1);
      end else if (h_eff > HSizeBits'(MAX_HEIGHT)) begin
         h_eff = HSizeBits'(MAX_HEIGHT);
      end
   end

   assign col_p1   = WSizeBits'(col_ff) + WSizeBits'(1);
   assign row_p1   = HSizeBits'(row_ff) + HSizeBits'(1);
   assign row_end  = (col_p1 >= w_eff);
   assign last_row = (row_p1 >= h_eff);
   assign col_x    = (ColBits + 8)'(col_ff);
   assign row_x    = (RowBits + 8)'(row_ff);

   always_comb begin
      col_in = ColBits'(col_p1);
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = last_row ? '0 : RowBits'(row_p1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      ctl_new.valid   = req_tvalid;
      ctl_new.col     = col_ff;
      ctl_new.bit_idx = row_x[2:0];
      ctl_new.first   = (row_x[2:0] == 3'd0);
      ctl_new.emit    = (row_x[2:0] == 3'd7) || last_row;
      ctl_new.last    = last_row && row_end;
      ctl_new.page    = row_x[7:3];
      ctl_new.column  = col_x[7:0];
   end

   a2m_blend u_blend (
      .clock      (clock),
      .enable     (adv),
      .alpha      (req_tdata[7:0]),
      .red        (req_tdata[15:8]),
      .green      (req_tdata[23:16]),
      .blue       (req_tdata[31:24]),
      .background (bg_ff),
      .rgb        (rgb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff      <= '0;
         s2_ff      <= '0;
         fwd_hit_ff <= 1'b0;
      end else if (adv) begin
         s1_ff      <= ctl_new;
         s2_ff      <= s1_ff;
         fwd_hit_ff <= s1_ff.valid && s2_ff.valid && (s1_ff.col == s2_ff.col);
      end
   end

   // Merge the pixel bit into its column byte; take the forwarded byte when
   // the read raced the write of the same column.
   assign pix_on   = (rgb != key_ff);
   assign bit_mask = pix_on ? (8'd1 << s2_ff.bit_idx) : 8'd0;
   assign old_byte = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign new_byte = s2_ff.first ? bit_mask : (old_byte | bit_mask);

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff       <= buf_mem[s1_ff.col];
         fwd_data_ff <= new_byte;
         if (s2_ff.valid) begin
            buf_mem[s2_ff.col] <= new_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s2_ff.valid && s2_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_byte_ff   <= new_byte;
         out_column_ff <= s2_ff.column;
         out_page_ff   <= s2_ff.page;
         out_last_ff   <= s2_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_page_ff, out_column_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;

   `A2M_ASSERT(a_col_wrap, (req_accept && row_end) |=> (col_ff == '0), "column did not wrap at row end")
   `A2M_ASSERT(a_col_step, (req_accept && !row_end) |=> (col_ff == $past(col_ff) + 1'b1), "column did not advance")
   `A2M_ASSERT_RST(a_rsp_reset, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

@@ verif/tb_argb_to_mono_page_packer.sv @@
// Self-checking testbench for the ARGB to mono page packer: directed rows, then random images.
`timescale 1ns / 1ps

module tb_argb_to_mono_page_packer;
   import a2m_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic       last_byte;
      logic [4:0] page;
      logic [7:0] column;
      logic [7:0] page_byte;
   } column_byte_type;

   typedef enum {STEP_PIXEL, STEP_REG} step_kind_type;

   typedef struct {
      step_kind_type   kind;
      a2m_reg_type     idx;
      logic [23:0]     value;
      pixel_type       px;
      bit              typed;
      column_byte_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // alpha[7:0], red[15:8], green[23:16], blue[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // page_byte[7:0], column[15:8], page[20:16], zero pad
   logic        rsp_tlast;   // last_byte
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_data;

   argb_to_mono_page_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Packer state as seen from outside, kept in step with accepted beats.
   logic [23:0] key_rgb;
   logic [23:0] under_rgb;
   logic [8:0]  width_raw;
   logic [8:0]  height_raw;
   int          col_pos;
   int          row_pos;
   logic [7:0]  column_bytes [MaxWidthDef];

   column_byte_type pending_bytes [$];
   plan_row_type    plan [$];

   int idle_pct = 20;
   int errors = 0;
   int bytes_checked = 0;
   int pixels_sent = 0;
   int settings_changes = 0;

   function automatic int eff_size(input logic [8:0] v, input int limit);
      if (v == 9'd0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic logic [7:0] blend_channel(input logic [7:0] c, bg, a);
      int unsigned mix;
      mix = 32'(c) * 32'(a) + 32'(bg) * (32'd255 - 32'(a));
      return 8'(mix / 32'd255);
   endfunction

   // Merge one pixel into its column byte; returns 1 when the byte goes out.
   function automatic bit pack_pixel(input pixel_type px, output column_byte_type res);
      int         w;
      int         h;
      bit         row_end;
      bit         last_row;
      bit         emit;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] bit_mask;
      w = eff_size(width_raw, MaxWidthDef);
      h = eff_size(height_raw, MaxHeightDef);
      row_end  = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      r = px.red;
      g = px.green;
      b = px.blue;
      if (px.alpha != 8'hFF) begin
         r = blend_channel(px.red, under_rgb[23:16], px.alpha);
         g = blend_channel(px.green, under_rgb[15:8], px.alpha);
         b = blend_channel(px.blue, under_rgb[7:0], px.alpha);
      end
      bit_mask = ({r, g, b} != key_rgb) ? (8'd1 << (row_pos % 8)) : 8'd0;
      // first row of a page overwrites the entry
      if (row_pos % 8 == 0)
         column_bytes[col_pos] = bit_mask;
      else
         column_bytes[col_pos] = column_bytes[col_pos] | bit_mask;
      res.page_byte = column_bytes[col_pos];
      res.column    = col_pos[7:0];
      res.page      = row_pos[7:3];
      res.last_byte = last_row && row_end;
      // a byte leaves on the last row of a page or of the image
      emit = (row_pos % 8 == 7) || last_row;
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return emit;
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type px;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 40)
         px.alpha = 8'hFF;
      else if (pick < 55)
         px.alpha = 8'h00;
      else
         px.alpha = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 35)
         {px.red, px.green, px.blue} = key_rgb;
      else if (pick < 50)
         {px.red, px.green, px.blue} = under_rgb;
      else
         {px.red, px.green, px.blue} = 24'($urandom);
      return px;
   endfunction

   function automatic logic [23:0] pick_color();
      case ($urandom_range(3))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic void plan_reg(input a2m_reg_type idx, input logic [23:0] value);
      plan_row_type row;
      row = '{kind: STEP_REG, idx: idx, value: value, px: '0, typed: 1'b0, want: '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_pixel(input logic [7:0] alpha, input logic [23:0] rgb,
                                      input bit typed, input logic [7:0] page_byte,
                                      input logic [7:0] column, input logic [4:0] page,
                                      input logic last_byte);
      plan_row_type row;
      row.kind  = STEP_PIXEL;
      row.idx   = REG_KEY_COLOR;
      row.value = '0;
      row.px    = {rgb[7:0], rgb[15:8], rgb[23:16], alpha};
      row.typed = typed;
      row.want  = {last_byte, page, column, page_byte};
      plan.push_back(row);
   endfunction

   // Send one pixel beat; an optional idle burst goes before it.
   task automatic send_pixel(input pixel_type px, input bit typed,
                             input column_byte_type want);
      column_byte_type predicted;
      bit              emit;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(11, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      emit = pack_pixel(px, predicted);
      if (typed)
         pending_bytes.push_back(want);
      else if (emit)
         pending_bytes.push_back(predicted);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Hold the pixel stream until every column byte owed has come out.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(input a2m_reg_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_KEY_COLOR:        key_rgb = value;
         REG_BACKGROUND_COLOR: under_rgb = value;
         REG_IMAGE_WIDTH:      width_raw = value[8:0];
         REG_IMAGE_HEIGHT:     height_raw = value[8:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [23:0] key, bg, input logic [8:0] w, h,
                                 input logic [3:0] which);
      wait_idle();
      if (which[0]) write_reg(REG_KEY_COLOR, key);
      if (which[1]) write_reg(REG_BACKGROUND_COLOR, bg);
      if (which[2]) write_reg(REG_IMAGE_WIDTH, {15'd0, w});
      if (which[3]) write_reg(REG_IMAGE_HEIGHT, {15'd0, h});
      csr_valid <= 1'b0;
      settings_changes++;
   endtask

   // Receiver side: random stall bursts on rsp_tready.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(10, 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every column byte beat with the oldest one owed.
   always @(posedge clock) begin
      column_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("column byte with none owed: data %h last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.page_byte) begin
               $error("page_byte: expected %h, got %h", want.page_byte, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[20:16] !== want.page) begin
               $error("page: expected %0d, got %0d", want.page, rsp_tdata[20:16]);
               errors++;
            end
            if (rsp_tlast !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_tlast);
               errors++;
            end
            bytes_checked++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int          phase;
      int          n;
      logic [23:0] key;
      logic [23:0] bg;
      logic [8:0]  w;
      logic [8:0]  h;
      logic [3:0]  which;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_KEY_COLOR;
      csr_data   = '0;
      key_rgb    = 24'h000000;
      under_rgb  = 24'h000000;
      width_raw  = WidthReset;
      height_raw = HeightReset;
      col_pos    = 0;
      row_pos    = 0;
      foreach (column_bytes[i]) column_bytes[i] = 8'h00;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Two columns, nine rows: one full page, then a one-row partial page.
      plan_reg(REG_IMAGE_WIDTH, 24'd2);
      plan_reg(REG_IMAGE_HEIGHT, 24'd9);
      plan_pixel(8'd255, 24'hFFFFFF, 0, 0, 0, 0, 0);
      plan_pixel(8'd0,   24'hFFFFFF, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'h000000, 0, 0, 0, 0, 0);
      plan_pixel(8'd1,   24'hFFFFFF, 0, 0, 0, 0, 0);
      plan_pixel(8'd254, 24'h000001, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'h000001, 0, 0, 0, 0, 0);
      plan_pixel(8'd128, 24'hFF0000, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'h800000, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'hFFFFFF, 0, 0, 0, 0, 0);
      plan_pixel(8'd0,   24'h000000, 0, 0, 0, 0, 0);
      plan_pixel(8'd0,   24'hFF00FF, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'h00FF00, 0, 0, 0, 0, 0);
      plan_pixel(8'd255, 24'h0000FF, 0, 0, 0, 0, 0);
      plan_pixel(8'd2,   24'h010101, 0, 0, 0, 0, 0);
      plan_pixel(8'd127, 24'hFFFFFF, 1, 8'hD9, 8'd0, 5'd0, 1'b0);
      plan_pixel(8'd255, 24'hFFFFFF, 1, 8'hAE, 8'd1, 5'd0, 1'b0);
      plan_pixel(8'd255, 24'h000000, 1, 8'h00, 8'd0, 5'd1, 1'b0);
      plan_pixel(8'd255, 24'hFFFFFF, 1, 8'h01, 8'd1, 5'd1, 1'b1);
      // White key and background, zero sizes acting as a one-pixel image.
      plan_reg(REG_KEY_COLOR, 24'hFFFFFF);
      plan_reg(REG_BACKGROUND_COLOR, 24'hFFFFFF);
      plan_reg(REG_IMAGE_WIDTH, 24'd0);
      plan_reg(REG_IMAGE_HEIGHT, 24'd0);
      plan_pixel(8'd0,   24'h000000, 1, 8'h00, 8'd0, 5'd0, 1'b1);
      plan_pixel(8'd255, 24'hFFFFFF, 1, 8'h00, 8'd0, 5'd0, 1'b1);
      plan_pixel(8'd255, 24'hFFFFFE, 1, 8'h01, 8'd0, 5'd0, 1'b1);
      plan_pixel(8'd128, 24'h000000, 0, 0, 0, 0, 0);

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_REG) begin
            if (i == 0 || plan[i-1].kind == STEP_PIXEL) wait_idle();
            write_reg(plan[i].idx, plan[i].value);
            if (i + 1 == plan.size() || plan[i+1].kind != STEP_REG) csr_valid <= 1'b0;
         end else begin
            send_pixel(plan[i].px, plan[i].typed, plan[i].want);
         end
      end

      phase = 0;
      while (pixels_sent < 600) begin
         if (phase == 1 || phase == 3) begin
            // finish the open image so the next one starts at column 0, row 0
            while (row_pos != 0 || col_pos != 0) begin
               send_pixel(rand_pixel(), 1'b0, '0);
            end
            if (phase == 1) begin
               apply_settings(pick_color(), pick_color(), 9'd300, 9'd1, 4'b1111);
            end else begin
               idle_pct = 0;
               apply_settings(pick_color(), pick_color(), 9'd1, 9'd511, 4'b1111);
            end
            repeat (256) send_pixel(rand_pixel(), 1'b0, '0);
         end else begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
            if (pixels_sent >= 500) idle_pct = 0;
            bg  = pick_color();
            key = ($urandom_range(2) == 0) ? bg : pick_color();
            w = ($urandom_range(7) == 0) ? 9'd0 : 9'($urandom_range(12, 1));
            h = ($urandom_range(7) == 0) ? 9'd0 : 9'($urandom_range(20, 1));
            which = (phase == 0) ? 4'b1111 : 4'($urandom_range(15, 1));
            // grow the width only at a page start, where every entry is rewritten
            if (eff_size(w, MaxWidthDef) > eff_size(width_raw, MaxWidthDef) && row_pos % 8 != 0)
               w = width_raw;
            apply_settings(key, bg, w, h, which);
            n = $urandom_range(60, 1);
            repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $error("%0d column bytes never came out", pending_bytes.size());
         errors++;
      end
      $display("Sent %0d pixels across %0d register settings, incl. full-width and full-height",
               pixels_sent, settings_changes);
      $display("images; checked %0d column bytes with stalls on both streams.", bytes_checked);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/a2m_pkg.sv
rtl/a2m_blend.sv
rtl/argb_to_mono_page_packer.sv
verif/tb_argb_to_mono_page_packer.sv
